// ===== rtl/thc_pkg.sv =====
// thc_pkg: shared types, constants and arithmetic helpers for the
// temperature and humidity compensation pipeline
// no dependencies
`timescale 1ns / 1ps

package thc_pkg;

	localparam int RAW_T_W = 20;
	localparam int RAW_H_W = 16;
	localparam int TEMP_W  = 24;
	localparam int HUM_W   = 17;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 32;

	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 48;

	// register stages in the humidity segment, stage 4 up to the output register
	localparam int HUM_STAGES = 8;

	localparam logic [31:0] HUM_X_OFFSET   = 32'd76800;
	localparam logic [31:0] HUM_A_ROUND    = 32'd16384;
	localparam logic [31:0] HUM_C_OFFSET   = 32'd32768;
	localparam logic [31:0] HUM_E_OFFSET   = 32'd2097152;
	localparam logic [31:0] HUM_F_ROUND    = 32'd8192;
	localparam logic [31:0] HUM_CLAMP_MAX  = 32'd419430400;
	localparam logic [31:0] TEMP_ROUND     = 32'd128;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TEMP_COEF_ONE      = 3'd0,
		REG_TEMP_COEF_TWO      = 3'd1,
		REG_TEMP_COEF_THREE    = 3'd2,
		REG_HUM_COEF_ONE       = 3'd3,
		REG_HUM_COEF_TWO       = 3'd4,
		REG_HUM_COEF_THREE     = 3'd5,
		REG_HUM_COEF_FOUR_FIVE = 3'd6,
		REG_HUM_COEF_SIX       = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [15:0] t1;
		logic [15:0] t2;
		logic [15:0] t3;
		logic [7:0]  h1;
		logic [15:0] h2;
		logic [7:0]  h3;
		logic [31:0] h45;
		logic [7:0]  h6;
	} coef_t;

	typedef struct packed {
		logic [31:0]        fine;
		logic [RAW_H_W-1:0] raw_h;
	} temp_out_t;

	function automatic logic [31:0] sx16(input logic [15:0] v);
		sx16 = {{16{v[15]}}, v};
	endfunction

	function automatic logic [31:0] sx8(input logic [7:0] v);
		sx8 = {{24{v[7]}}, v};
	endfunction

	function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] s);
		logic signed [31:0] sv;
		sv = $signed(v);
		asr = $unsigned(sv >>> s);
	endfunction

	function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
		mul32 = a * b;
	endfunction

endpackage

// ===== rtl/thc_cfg.sv =====
// thc_cfg: calibration coefficient register file with its write channel
// depends on thc_pkg
`timescale 1ns / 1ps

module thc_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [thc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [thc_pkg::CFG_DAT_W-1:0]  cfg_data,
	output thc_pkg::coef_t                 coef
);

	thc_pkg::coef_t coef_q;

	assign cfg_ready = 1'b1;
	assign coef = coef_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (thc_pkg::cfg_reg_t'(cfg_index))
				thc_pkg::REG_TEMP_COEF_ONE:      coef_q.t1  <= cfg_data[15:0];
				thc_pkg::REG_TEMP_COEF_TWO:      coef_q.t2  <= cfg_data[15:0];
				thc_pkg::REG_TEMP_COEF_THREE:    coef_q.t3  <= cfg_data[15:0];
				thc_pkg::REG_HUM_COEF_ONE:       coef_q.h1  <= cfg_data[7:0];
				thc_pkg::REG_HUM_COEF_TWO:       coef_q.h2  <= cfg_data[15:0];
				thc_pkg::REG_HUM_COEF_THREE:     coef_q.h3  <= cfg_data[7:0];
				thc_pkg::REG_HUM_COEF_FOUR_FIVE: coef_q.h45 <= cfg_data[31:0];
				thc_pkg::REG_HUM_COEF_SIX:       coef_q.h6  <= cfg_data[7:0];
				default:                         coef_q     <= coef_q;
			endcase
		end
	end

endmodule

// ===== rtl/thc_temp.sv =====
// thc_temp: stages 1 to 3, fine temperature from the raw temperature reading
// depends on thc_pkg
`timescale 1ns / 1ps

module thc_temp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  thc_pkg::coef_t                coef,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [thc_pkg::RAW_T_W-1:0]   raw_t,
	input  logic [thc_pkg::RAW_H_W-1:0]   raw_h,
	output logic                          out_valid,
	input  logic                          out_ready,
	output thc_pkg::temp_out_t            out_data
);

	logic v_s1, v_s2, v_s3;
	logic adv_s1, adv_s2, adv_s3;

	logic [31:0] at_w, d_w;
	logic [31:0] p1m_s1, dd_s1;
	logic [31:0] p1_s2, p2m_s2;
	logic [31:0] fine_s3;
	logic [thc_pkg::RAW_H_W-1:0] raw_h_s1, raw_h_s2, raw_h_s3;

	assign adv_s3 = !v_s3 || out_ready;
	assign adv_s2 = !v_s2 || adv_s3;
	assign adv_s1 = !v_s1 || adv_s2;
	assign in_ready = adv_s1;

	assign at_w = {15'b0, raw_t[19:3]} - {15'b0, coef.t1, 1'b0};
	assign d_w  = {16'b0, raw_t[19:4]} - {16'b0, coef.t1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= in_valid;
			if (adv_s2) v_s2 <= v_s1;
			if (adv_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			p1m_s1   <= thc_pkg::mul32(at_w, thc_pkg::sx16(coef.t2));
			dd_s1    <= thc_pkg::mul32(d_w, d_w);
			raw_h_s1 <= raw_h;
		end
		if (adv_s2) begin
			p1_s2    <= thc_pkg::asr(p1m_s1, 5'd11);
			p2m_s2   <= thc_pkg::mul32(thc_pkg::asr(dd_s1, 5'd12), thc_pkg::sx16(coef.t3));
			raw_h_s2 <= raw_h_s1;
		end
		if (adv_s3) begin
			fine_s3  <= p1_s2 + thc_pkg::asr(p2m_s2, 5'd14);
			raw_h_s3 <= raw_h_s2;
		end
	end

	assign out_valid      = v_s3;
	assign out_data.fine  = fine_s3;
	assign out_data.raw_h = raw_h_s3;

`ifndef NO_ASSERTIONS
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s1)
		else $error("accepted transaction did not reach stage 1");
	a_bubble_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s3 |-> in_ready)
		else $error("input stalled while last stage is empty");
`endif

endmodule

// ===== rtl/thc_hum.sv =====
// thc_hum: stages 4 to 11, temperature scaling and the humidity formula
// with clamp; stage 11 is the output register
// depends on thc_pkg
`timescale 1ns / 1ps

module thc_hum (
	input  logic                          clk,
	input  logic                          arst_n,
	input  thc_pkg::coef_t                coef,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  thc_pkg::temp_out_t            in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [thc_pkg::TEMP_W-1:0]    temp_out,
	output logic [thc_pkg::HUM_W-1:0]     hum_out
);

	logic [thc_pkg::HUM_STAGES-1:0] v_s;
	logic [thc_pkg::HUM_STAGES-1:0] adv_s;

	logic [31:0] x_w, tc_w, t_w, a_w, e_w, f_w, q_w, r_w;
	logic [thc_pkg::HUM_W-1:0] hum_w;

	logic [thc_pkg::TEMP_W-1:0] temp_s4, temp_s5, temp_s6, temp_s7, temp_s8,
		temp_s9, temp_s10, temp_s11;
	logic [thc_pkg::RAW_H_W-1:0] raw_h_s4;
	logic [31:0] xh5_s4, xh6_s4, xh3_s4;
	logic [31:0] a_s5, b_s5, c_s5;
	logic [31:0] a_s6, bc_s6;
	logic [31:0] a_s7, eh2_s7;
	logic [31:0] af_s8;
	logic [31:0] af_s9, qq_s9;
	logic [31:0] af_s10, qqh1_s10;
	logic [thc_pkg::HUM_W-1:0] hum_s11;

	always_comb begin
		adv_s[thc_pkg::HUM_STAGES-1] = !v_s[thc_pkg::HUM_STAGES-1] || out_ready;
		for (int k = thc_pkg::HUM_STAGES - 2; k >= 0; k--) begin
			adv_s[k] = !v_s[k] || adv_s[k+1];
		end
	end
	assign in_ready = adv_s[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			if (adv_s[0]) v_s[0] <= in_valid;
			for (int k = 1; k < thc_pkg::HUM_STAGES; k++) begin
				if (adv_s[k]) v_s[k] <= v_s[k-1];
			end
		end
	end

	// stage 4 operands
	assign x_w  = in_data.fine - thc_pkg::HUM_X_OFFSET;
	assign tc_w = {in_data.fine[29:0], 2'b0} + in_data.fine + thc_pkg::TEMP_ROUND;
	assign t_w  = thc_pkg::asr(tc_w, 5'd8);

	// stage 5 operand
	assign a_w = thc_pkg::asr({2'b0, raw_h_s4, 14'b0} - {coef.h45[27:16], 20'b0}
		- xh5_s4 + thc_pkg::HUM_A_ROUND, 5'd15);

	// stage 7, 8, 9 operands
	assign e_w = thc_pkg::asr(bc_s6, 5'd10) + thc_pkg::HUM_E_OFFSET;
	assign f_w = thc_pkg::asr(eh2_s7 + thc_pkg::HUM_F_ROUND, 5'd14);
	assign q_w = thc_pkg::asr(af_s8, 5'd15);

	// stage 11: correction and clamp to 0..100 percent
	always_comb begin
		r_w = af_s10 - thc_pkg::asr(qqh1_s10, 5'd4);
		priority if (r_w[31]) begin
			hum_w = '0;
		end else if (r_w > thc_pkg::HUM_CLAMP_MAX) begin
			hum_w = thc_pkg::HUM_CLAMP_MAX[28:12];
		end else begin
			hum_w = r_w[28:12];
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s[0]) begin
			temp_s4  <= t_w[thc_pkg::TEMP_W-1:0];
			raw_h_s4 <= in_data.raw_h;
			xh5_s4   <= thc_pkg::mul32(thc_pkg::sx16(coef.h45[15:0]), x_w);
			xh6_s4   <= thc_pkg::mul32(x_w, thc_pkg::sx8(coef.h6));
			xh3_s4   <= thc_pkg::mul32(x_w, {24'b0, coef.h3});
		end
		if (adv_s[1]) begin
			temp_s5 <= temp_s4;
			a_s5    <= a_w;
			b_s5    <= thc_pkg::asr(xh6_s4, 5'd10);
			c_s5    <= thc_pkg::asr(xh3_s4, 5'd11) + thc_pkg::HUM_C_OFFSET;
		end
		if (adv_s[2]) begin
			temp_s6 <= temp_s5;
			a_s6    <= a_s5;
			bc_s6   <= thc_pkg::mul32(b_s5, c_s5);
		end
		if (adv_s[3]) begin
			temp_s7 <= temp_s6;
			a_s7    <= a_s6;
			eh2_s7  <= thc_pkg::mul32(e_w, thc_pkg::sx16(coef.h2));
		end
		if (adv_s[4]) begin
			temp_s8 <= temp_s7;
			af_s8   <= thc_pkg::mul32(a_s7, f_w);
		end
		if (adv_s[5]) begin
			temp_s9 <= temp_s8;
			af_s9   <= af_s8;
			qq_s9   <= thc_pkg::mul32(q_w, q_w);
		end
		if (adv_s[6]) begin
			temp_s10 <= temp_s9;
			af_s10   <= af_s9;
			qqh1_s10 <= thc_pkg::mul32(thc_pkg::asr(qq_s9, 5'd7), {24'b0, coef.h1});
		end
		if (adv_s[7]) begin
			temp_s11 <= temp_s10;
			hum_s11  <= hum_w;
		end
	end

	assign out_valid = v_s[thc_pkg::HUM_STAGES-1];
	assign temp_out  = temp_s11;
	assign hum_out   = hum_s11;

`ifndef NO_ASSERTIONS
	a_hum_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> hum_s11 <= thc_pkg::HUM_CLAMP_MAX[28:12])
		else $error("humidity above 100 percent at output");
	a_bubble_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s[thc_pkg::HUM_STAGES-1] |-> in_ready)
		else $error("humidity pipeline stalled while output stage is empty");
`endif

endmodule

// ===== rtl/temp_humidity_compensation.sv =====
// temp_humidity_compensation: top level, coefficient registers plus the
// temperature and humidity pipeline segments
// depends on thc_pkg, thc_cfg, thc_temp, thc_hum
`timescale 1ns / 1ps

// Compensates one raw temperature and humidity reading per transaction using
// the calibration coefficients written over the cfg channel (always ready,
// index 0..7). The datapath is an 11-stage pipeline with at most three 32-bit
// multiplies per stage: it takes one reading per clock while it is not
// stalled, and each result passes through stages 1 to 11 and is held in the
// stage 11 output register until m_axis takes it. Each stage holds its data
// when the stage after it is full and cannot advance, so back-pressure on
// m_axis fills bubbles before s_axis_tready falls. Coefficients are used live
// and should be written only while the pipeline is empty.
module temp_humidity_compensation (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// [19:0] raw_temperature, [35:20] raw_humidity, [39:36] zero
	input  logic [thc_pkg::S_TDATA_W-1:0]  s_axis_tdata,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// [23:0] temperature_centi, [40:24] humidity_q10, [47:41] zero
	output logic [thc_pkg::M_TDATA_W-1:0]  m_axis_tdata,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [thc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [thc_pkg::CFG_DAT_W-1:0]  cfg_data
);

	thc_pkg::coef_t     coef;
	thc_pkg::temp_out_t mid_data;
	logic               mid_valid, mid_ready;
	logic [thc_pkg::TEMP_W-1:0] temp_out;
	logic [thc_pkg::HUM_W-1:0]  hum_out;

	thc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coef      (coef)
	);

	thc_temp u_temp (
		.clk       (clk),
		.arst_n    (arst_n),
		.coef      (coef),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.raw_t     (s_axis_tdata[19:0]),
		.raw_h     (s_axis_tdata[35:20]),
		.out_valid (mid_valid),
		.out_ready (mid_ready),
		.out_data  (mid_data)
	);

	thc_hum u_hum (
		.clk       (clk),
		.arst_n    (arst_n),
		.coef      (coef),
		.in_valid  (mid_valid),
		.in_ready  (mid_ready),
		.in_data   (mid_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.temp_out  (temp_out),
		.hum_out   (hum_out)
	);

	assign m_axis_tdata = {7'b0, hum_out, temp_out};

endmodule
